// ===== hdl/png_chunk_deframer_unit_defines.svh =====
// Assertion macros shared by the PNG chunk deframer RTL.
`ifndef PNG_CHUNK_DEFRAMER_UNIT_DEFINES_SVH
`define PNG_CHUNK_DEFRAMER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked property, suspended while reset is high.
`define PCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also evaluated during reset.
`define PCD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCD_ASSERT(label, clk, rst, prop, msg)
`define PCD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hdl/pcd_pkg.sv =====
// Types, codes, tables and CRC/classify functions of the PNG chunk deframer.
`default_nettype none

package pcd_pkg;

   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 3;
   localparam int CODE_W   = 4;
   localparam int STATUS_W = 3;
   localparam int MAXLEN_W = 31;
   localparam int LEN_W    = 32;
   localparam int CRC_W    = 32;

   localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 31'h7FFF_FFFF;
   localparam logic [CRC_W-1:0]    CRC_INIT     = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0]    CRC_POLY     = 32'hEDB8_8320;

   typedef enum logic [KIND_W-1:0] {
      KIND_SIG  = 3'd0,
      KIND_LEN  = 3'd1,
      KIND_TYPE = 3'd2,
      KIND_DATA = 3'd3,
      KIND_CRC  = 3'd4
   } kind_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_UNKNOWN = 4'd0,
      CODE_IHDR    = 4'd1,
      CODE_PLTE    = 4'd2,
      CODE_TRNS    = 4'd3,
      CODE_ACTL    = 4'd4,
      CODE_IDAT    = 4'd5,
      CODE_FCTL    = 4'd6,
      CODE_FDAT    = 4'd7,
      CODE_IEND    = 4'd8
   } code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_BAD_SIG = 3'd1,
      ST_LEN_BIG = 3'd2,
      ST_BAD_CRC = 3'd3,
      ST_HALTED  = 3'd4
   } status_type;

   typedef enum logic [5:0] {
      PH_SIG  = 6'b000001,
      PH_LEN  = 6'b000010,
      PH_TYPE = 6'b000100,
      PH_DATA = 6'b001000,
      PH_CRC  = 6'b010000,
      PH_HALT = 6'b100000
   } phase_type;

   typedef logic [BYTE_W-1:0] sig_table_type [8];
   localparam sig_table_type SIG_BYTES = '{
      8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
   };

   typedef logic [31:0] type_table_type [8];
   localparam type_table_type KNOWN_TYPES = '{
      32'h4948_4452,  // IHDR
      32'h504C_5445,  // PLTE
      32'h7452_4E53,  // tRNS
      32'h6163_544C,  // acTL
      32'h4944_4154,  // IDAT
      32'h6663_544C,  // fcTL
      32'h6664_4154,  // fdAT
      32'h4945_4E44   // IEND
   };

   // Result item as registered by the engine.
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      kind_type          byte_kind;
      code_type          type_code;
      logic              chunk_done;
      status_type        status;
   } rsp_type;

   // Queue head as seen by the engine.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } head_type;

   // One reflected CRC-32 byte update, bit by bit.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic code_type classify(input logic [31:0] t);
      code_type code;
      code = CODE_UNKNOWN;
      for (int i = 0; i < 8; i++) begin
         if (KNOWN_TYPES[i] == t) begin
            code = code_type'(CODE_W'(i + 1));
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/pcd_queue.sv =====
// Front end: takes input items into a short byte queue.
`default_nettype none
`include "png_chunk_deframer_unit_defines.svh"

module pcd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [pcd_pkg::BYTE_W-1:0] req_in_byte,
   output      pcd_pkg::head_type        head,
   input  wire logic                     pop
);
   import pcd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [BYTE_W-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;

   assign req_stall  = (count_ff == CNT_FULL);
   assign push       = req_valid && !req_stall;
   assign head.valid = (count_ff != '0);
   assign head.data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= req_in_byte;
      end
   end

   `PCD_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_FULL, "queue count above depth")
   `PCD_ASSERT(a_no_pop_empty, clock, reset, pop |-> head.valid, "pop from empty queue")
   `PCD_ASSERT(a_count_step, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1),
      "queue count missed a push")

endmodule

`default_nettype wire

// ===== hdl/pcd_engine.sv =====
// Back end: signature check, chunk deframing, CRC check, result register.
`default_nettype none
`include "png_chunk_deframer_unit_defines.svh"

module pcd_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic [pcd_pkg::MAXLEN_W-1:0] csr_write_data,
   input  wire pcd_pkg::head_type            head,
   output      logic                         pop,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      pcd_pkg::rsp_type             rsp
);
   import pcd_pkg::*;

   logic [MAXLEN_W-1:0] max_len_ff;
   phase_type           phase_ff, phase_in;
   logic [MAXLEN_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [23:0]         typ_ff, typ_in;   // first three type bytes
   logic [CRC_W-1:0]    crc_ff, crc_in;
   logic [23:0]         rcv_ff, rcv_in;   // first three CRC bytes
   code_type            code_ff, code_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                advance;

   assign advance   = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop       = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      logic [BYTE_W-1:0]   b;
      logic [LEN_W-1:0]    new_len;
      logic [CRC_W-1:0]    crc_upd;
      logic [MAXLEN_W-1:0] cnt_nx;
      logic                last4;

      b       = head.data;
      new_len = {len_ff[23:0], b};
      crc_upd = crc_byte(crc_ff, b);
      cnt_nx  = cnt_ff + 1'b1;
      last4   = (cnt_ff >= MAXLEN_W'(3));

      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      typ_in   = typ_ff;
      crc_in   = crc_ff;
      rcv_in   = rcv_ff;
      code_in  = code_ff;

      rsp_in.out_byte   = b;
      rsp_in.byte_kind  = KIND_SIG;
      rsp_in.type_code  = CODE_UNKNOWN;
      rsp_in.chunk_done = 1'b0;
      rsp_in.status     = ST_OK;

      case (phase_ff)
         PH_SIG: begin
            if (b != SIG_BYTES[cnt_ff[2:0]]) begin
               rsp_in.status = ST_BAD_SIG;
               phase_in      = PH_HALT;
            end else if (cnt_ff >= MAXLEN_W'(7)) begin
               cnt_in   = '0;
               phase_in = PH_LEN;
            end else begin
               cnt_in = cnt_nx;
            end
         end
         PH_LEN: begin
            rsp_in.byte_kind = KIND_LEN;
            len_in           = new_len;
            if (last4) begin
               cnt_in = '0;
               if (new_len > {1'b0, max_len_ff}) begin
                  rsp_in.status = ST_LEN_BIG;
                  phase_in      = PH_HALT;
               end else begin
                  crc_in   = CRC_INIT;
                  phase_in = PH_TYPE;
               end
            end else begin
               cnt_in = cnt_nx;
            end
         end
         PH_TYPE: begin
            rsp_in.byte_kind = KIND_TYPE;
            typ_in           = {typ_ff[15:0], b};
            crc_in           = crc_upd;
            if (last4) begin
               code_in          = classify({typ_ff, b});
               rsp_in.type_code = code_in;
               cnt_in           = '0;
               phase_in         = (len_ff == '0) ? PH_CRC : PH_DATA;
            end else begin
               cnt_in = cnt_nx;
            end
         end
         PH_DATA: begin
            rsp_in.byte_kind = KIND_DATA;
            rsp_in.type_code = code_ff;
            crc_in           = crc_upd;
            if ({1'b0, cnt_nx} >= len_ff) begin
               cnt_in   = '0;
               phase_in = PH_CRC;
            end else begin
               cnt_in = cnt_nx;
            end
         end
         PH_CRC: begin
            rsp_in.byte_kind = KIND_CRC;
            rsp_in.type_code = code_ff;
            rcv_in           = {rcv_ff[15:0], b};
            if (last4) begin
               rsp_in.chunk_done = 1'b1;
               cnt_in            = '0;
               if (~crc_ff != {rcv_ff, b}) begin
                  rsp_in.status = ST_BAD_CRC;
                  phase_in      = PH_HALT;
               end else begin
                  phase_in = PH_LEN;
               end
            end else begin
               cnt_in = cnt_nx;
            end
         end
         default: begin
            rsp_in.status = ST_HALTED;
            phase_in      = PH_HALT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAXLEN_RESET;
      end else if (csr_write_enable) begin
         max_len_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIG;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff     <= phase_in;
            cnt_ff       <= cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Length, type, CRC and received CRC are fully reloaded before use.
   always_ff @(posedge clock) begin
      if (advance) begin
         len_ff  <= len_in;
         typ_ff  <= typ_in;
         crc_ff  <= crc_in;
         rcv_ff  <= rcv_in;
         code_ff <= code_in;
         rsp_ff  <= rsp_in;
      end
   end

   `PCD_ASSERT(a_halt_sticky, clock, reset, (phase_ff == PH_HALT) |=> (phase_ff == PH_HALT),
      "engine left halt without reset")
   `PCD_ASSERT(a_crc_err_done, clock, reset,
      (rsp_valid_ff && rsp_ff.status == ST_BAD_CRC) |-> rsp_ff.chunk_done,
      "crc error without chunk end")
   `PCD_ASSERT(a_pop_loads_rsp, clock, reset, pop |=> rsp_valid_ff,
      "popped item produced no result")

endmodule

`default_nettype wire

// ===== hdl/png_chunk_deframer_unit.sv =====
// Top level of the PNG chunk deframer: input queue and deframing engine.
//
//   port group   dir   handshake                   payload
//   req_         in    req_valid / req_stall       req_in_byte
//   rsp_         out   rsp_valid / rsp_stall       rsp_out_byte, rsp_byte_kind, rsp_type_code,
//                                                  rsp_chunk_done, rsp_status
//   csr_         in    csr_write_enable            csr_write_data (max chunk length)
//
// Sustained rate is one byte per cycle while rsp_stall is low; the engine's byte-wide CRC
// update and state step are combinational. A result is registered after its byte is
// taken (queue write at the accepting edge, result register when the engine pops it). Reset
// is synchronous and needs no clearing pass. rsp_stall only holds the result
// register; the queue keeps taking bytes until its QUEUE_DEPTH entries are full,
// then req_stall rises.
`default_nettype none

module png_chunk_deframer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic [pcd_pkg::BYTE_W-1:0]   req_in_byte,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [pcd_pkg::BYTE_W-1:0]   rsp_out_byte,
   output      logic [pcd_pkg::KIND_W-1:0]   rsp_byte_kind,
   output      logic [pcd_pkg::CODE_W-1:0]   rsp_type_code,
   output      logic                         rsp_chunk_done,
   output      logic [pcd_pkg::STATUS_W-1:0] rsp_status,
   input  wire logic                         csr_write_enable,
   input  wire logic [pcd_pkg::MAXLEN_W-1:0] csr_write_data
);
   import pcd_pkg::*;

   head_type head;
   logic     pop;
   rsp_type  rsp;

   pcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .head        (head),
      .pop         (pop)
   );

   pcd_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp              (rsp)
   );

   assign rsp_out_byte   = rsp.out_byte;
   assign rsp_byte_kind  = rsp.byte_kind;
   assign rsp_type_code  = rsp.type_code;
   assign rsp_chunk_done = rsp.chunk_done;
   assign rsp_status     = rsp.status;

endmodule

`default_nettype wire

// ===== test/png_chunk_deframer_unit_tb.sv =====
// Self-checking testbench for the PNG chunk deframer: signature, chunk framing, CRC, halting.
module png_chunk_deframer_unit_tb;
   import pcd_pkg::*;

   localparam int PERIOD      = 12;
   localparam int PHASE_BYTES = 85;
   localparam int HOLD_CYCLES = 90;

   localparam logic [63:0]  PNG_MAGIC   = 64'h8950_4E47_0D0A_1A0A;
   localparam logic [255:0] CHUNK_NAMES = {
      32'h4948_4452, 32'h504C_5445, 32'h7452_4E53, 32'h6163_544C,
      32'h4944_4154, 32'h6663_544C, 32'h6664_4154, 32'h4945_4E44
   };
   localparam logic [30:0] LEN_LIMIT_MAX = 31'h7FFF_FFFF;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_in_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic [KIND_W-1:0]   rsp_byte_kind;
   logic [CODE_W-1:0]   rsp_type_code;
   logic                rsp_chunk_done;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_write_enable;
   logic [MAXLEN_W-1:0] csr_write_data;

   bit          calm;
   bit          halted_run;
   int          bytes_sent;
   int          phase_sent;
   int          chunks_sent;
   int          empty_chunks;
   int          limit_writes;
   logic [8:0]  codes_seen;
   string       closing_error;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
      end
      return c;
   endfunction

   function automatic code_type chunk_class(input logic [31:0] t);
      for (int k = 0; k < 8; k++) begin
         if (CHUNK_NAMES[255-32*k -: 32] == t) begin
            return code_type'(4'(k + 1));
         end
      end
      return CODE_UNKNOWN;
   endfunction

   class deframe_scoreboard;
      phase_type   phase;
      logic [30:0] count;
      logic [31:0] length;
      logic [31:0] ctype;
      logic [31:0] crc;
      logic [31:0] rx_crc;
      logic [30:0] max_len;
      rsp_type     pending_results[$];
      int          errors;
      int          checked;

      function new();
         max_len = LEN_LIMIT_MAX;
         phase   = PH_SIG;
         count   = '0;
         length  = '0;
         ctype   = '0;
         crc     = 32'hFFFF_FFFF;
         rx_crc  = '0;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_max_len(input logic [30:0] v);
         max_len = v;
      endfunction

      // advance the deframer state by one byte and queue the result it yields
      function void note_byte(input logic [7:0] b);
         rsp_type     r;
         logic [30:0] nxt;
         r.out_byte   = b;
         r.byte_kind  = KIND_SIG;
         r.type_code  = CODE_UNKNOWN;
         r.chunk_done = 1'b0;
         r.status     = ST_OK;
         case (phase)
            PH_SIG: begin
               if (b != PNG_MAGIC[63-8*count[2:0] -: 8]) begin
                  r.status = ST_BAD_SIG;
                  phase    = PH_HALT;
               end else if (count >= 7) begin
                  count  = '0;
                  length = '0;
                  phase  = PH_LEN;
               end else begin
                  count = count + 31'd1;
               end
            end
            PH_LEN: begin
               r.byte_kind = KIND_LEN;
               length = {length[23:0], b};
               if (count >= 3) begin
                  count = '0;
                  if (length > {1'b0, max_len}) begin
                     r.status = ST_LEN_BIG;
                     phase    = PH_HALT;
                  end else begin
                     ctype = '0;
                     crc   = 32'hFFFF_FFFF;
                     phase = PH_TYPE;
                  end
               end else begin
                  count = count + 31'd1;
               end
            end
            PH_TYPE: begin
               r.byte_kind = KIND_TYPE;
               ctype = {ctype[23:0], b};
               crc   = crc32_update(crc, b);
               if (count >= 3) begin
                  r.type_code = chunk_class(ctype);
                  count  = '0;
                  rx_crc = '0;
                  phase  = (length == 0) ? PH_CRC : PH_DATA;
               end else begin
                  count = count + 31'd1;
               end
            end
            PH_DATA: begin
               r.byte_kind = KIND_DATA;
               r.type_code = chunk_class(ctype);
               crc = crc32_update(crc, b);
               nxt = count + 31'd1;
               if ({1'b0, nxt} >= length) begin
                  count  = '0;
                  rx_crc = '0;
                  phase  = PH_CRC;
               end else begin
                  count = nxt;
               end
            end
            PH_CRC: begin
               r.byte_kind = KIND_CRC;
               r.type_code = chunk_class(ctype);
               rx_crc = {rx_crc[23:0], b};
               if (count >= 3) begin
                  r.chunk_done = 1'b1;
                  count = '0;
                  if (~crc != rx_crc) begin
                     r.status = ST_BAD_CRC;
                     phase    = PH_HALT;
                  end else begin
                     length = '0;
                     phase  = PH_LEN;
                  end
               end else begin
                  count = count + 31'd1;
               end
            end
            default: begin
               r.status = ST_HALTED;
            end
         endcase
         pending_results.push_back(r);
      endfunction

      function void check_result(input logic [7:0] ob, input logic [2:0] k,
                                 input logic [3:0] c, input logic d, input logic [2:0] s);
         rsp_type e;
         checked++;
         if (pending_results.size() == 0) begin
            $error("unexpected result item: out_byte %0h", ob);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         if (ob !== e.out_byte) begin
            $error("out_byte: expected %0h, got %0h", e.out_byte, ob);
            errors++;
         end
         if (k !== e.byte_kind) begin
            $error("byte_kind: expected %0d, got %0d", e.byte_kind, k);
            errors++;
         end
         if (c !== e.type_code) begin
            $error("type_code: expected %0d, got %0d", e.type_code, c);
            errors++;
         end
         if (d !== e.chunk_done) begin
            $error("chunk_done: expected %0d, got %0d", e.chunk_done, d);
            errors++;
         end
         if (s !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, s);
            errors++;
         end
      endfunction
   endclass

   deframe_scoreboard sb = new();

   png_chunk_deframer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_kind    (rsp_byte_kind),
      .rsp_type_code    (rsp_type_code),
      .rsp_chunk_done   (rsp_chunk_done),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #(PERIOD/2) clock = ~clock;
   end

   initial begin
      #(PERIOD * 400000);
      $display("png_chunk_deframer_unit_tb: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_byte(req_in_byte);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_out_byte, rsp_byte_kind, rsp_type_code, rsp_chunk_done, rsp_status);
      end
   end

   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   function automatic logic [31:0] pick_type();
      int          r;
      int          k;
      int          p;
      logic [31:0] t;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      p = $urandom_range(0, 3);
      t = CHUNK_NAMES[255-32*k -: 32];
      if (r < 75) return t;
      if (r < 88) return $urandom;
      // near miss on a known name
      t[8*p +: 8] = t[8*p +: 8] ^ 8'($urandom_range(1, 255));
      return t;
   endfunction

   function automatic logic [31:0] pick_len(input logic [30:0] lim);
      int          r;
      int unsigned cap;
      r   = $urandom_range(0, 99);
      cap = (lim < 24) ? lim : 24;
      if (r < 4) return $urandom_range(0, (lim < 300) ? lim : 300);
      if (r < 15) return cap;
      return $urandom_range(0, cap);
   endfunction

   // receiver: random stalls, plus one long hold-off while bytes are still offered
   initial begin
      int n;
      bit held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held && sb.checked >= 200 && req_valid) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            n = pick_gap(calm);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      phase_sent++;
      gap = pick_gap(calm);
      if (gap > 0) begin
         req_valid   <= 1'b0;
         req_in_byte <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_chunk(input logic [31:0] ctype, input logic [31:0] len,
                             input bit extremes, input bit corrupt);
      logic [31:0] crc;
      logic [7:0]  b;
      crc = 32'hFFFF_FFFF;
      chunks_sent++;
      if (len == 0) empty_chunks++;
      codes_seen[chunk_class(ctype)] = 1'b1;
      for (int i = 0; i < 4; i++) send_byte(len[31-8*i -: 8]);
      for (int i = 0; i < 4; i++) begin
         b   = ctype[31-8*i -: 8];
         crc = crc32_update(crc, b);
         send_byte(b);
      end
      for (int i = 0; i < len; i++) begin
         b   = extremes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
         crc = crc32_update(crc, b);
         send_byte(b);
      end
      crc = ~crc;
      if (corrupt) crc = crc ^ (32'h1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) send_byte(crc[31-8*i -: 8]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [30:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_max_len(v);
      limit_writes++;
   endtask

   initial begin
      int              bad_pos;
      logic [7:0]      b;
      logic [30:0]     lim;
      logic [31:0]     big_len;
      longint unsigned wide;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_in_byte      <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      calm          = 1'b0;
      bytes_sent    = 0;
      chunks_sent   = 0;
      empty_chunks  = 0;
      limit_writes  = 0;
      codes_seen    = '0;
      closing_error = "bad signature";
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      halted_run = ($urandom_range(0, 5) == 0);
      phase_sent = 0;
      if (halted_run) begin
         bad_pos = $urandom_range(0, 7);
         for (int i = 0; i < 8; i++) begin
            b = PNG_MAGIC[63-8*i -: 8];
            if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
            send_byte(b);
         end
      end else begin
         for (int i = 0; i < 8; i++) send_byte(PNG_MAGIC[63-8*i -: 8]);
         send_chunk(CHUNK_NAMES[255 -: 32], 32'd2, 1'b1, 1'b0);
         // empty IEND, then framing carries on
         send_chunk(CHUNK_NAMES[31:0], 32'd0, 1'b0, 1'b0);
      end

      // first phase runs on the reset value of the length limit
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            wait_drained();
            case (ph)
               1:       lim = '0;
               2:       lim = 31'd1;
               3:       lim = 31'($urandom_range(2, 40));
               4:       lim = LEN_LIMIT_MAX;
               default: lim = 31'($urandom);
            endcase
            write_max_len(lim);
            calm = (ph == 2) || ($urandom_range(0, 3) == 0);
         end
         phase_sent = 0;
         while (phase_sent < PHASE_BYTES) begin
            if (halted_run) begin
               send_byte(8'($urandom));
            end else begin
               send_chunk(pick_type(), pick_len(sb.max_len), 1'b0, 1'b0);
            end
         end
      end

      // one fatal error to close, then a few bytes into the halted state
      if (!halted_run) begin
         if ($urandom_range(0, 1) == 1) begin
            closing_error = "length too large";
            wide = longint'(sb.max_len) + 1 + $urandom_range(0, 1000);
            if (wide > 64'hFFFF_FFFF) wide = 64'hFFFF_FFFF;
            big_len = wide[31:0];
            for (int i = 0; i < 4; i++) send_byte(big_len[31-8*i -: 8]);
         end else begin
            closing_error = "crc mismatch";
            send_chunk(pick_type(), pick_len(sb.max_len), 1'b0, 1'b1);
         end
         repeat (20) send_byte(8'($urandom));
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("%0d bytes, %0d chunks (%0d empty), type codes seen %b, %0d limit writes",
               bytes_sent, chunks_sent, empty_chunks, codes_seen, limit_writes);
      $display("run closed on a %s error, %0d result items checked", closing_error, sb.checked);
      if (sb.errors == 0) begin
         $display("png_chunk_deframer_unit_tb: done, clean");
      end else begin
         $display("png_chunk_deframer_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pcd_pkg.sv
hdl/pcd_queue.sv
hdl/pcd_engine.sv
hdl/png_chunk_deframer_unit.sv
test/png_chunk_deframer_unit_tb.sv
